FILE: rtl/core/windowed_trimmed_mean_filter_macros.svh
// ----------------------------------------------------------------------------
// windowed trimmed mean filter assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef WINDOWED_TRIMMED_MEAN_FILTER_MACROS_SVH
`define WINDOWED_TRIMMED_MEAN_FILTER_MACROS_SVH

// same-cycle implication
`define WTM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WTM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/wtm_pkg.sv
// ----------------------------------------------------------------------------
// wtm_pkg
// types, constants and codes of the windowed trimmed mean filter
// ----------------------------------------------------------------------------
package wtm_pkg;

    localparam int WINDOW      = 40;
    localparam int TRIM_LOW    = 15;
    localparam int TRIM_COUNT  = 10;
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 20;
    localparam int MAG_W       = 19;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 23;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int QUOT_W      = SAMPLE_W + 1;
    localparam int CNT_W       = $clog2(2 * WINDOW);
    localparam int TAP_IDX_W   = $clog2(TRIM_COUNT);

    // ceil(2^23 / 10), exact for magnitudes below 2^19
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(838861);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = sample_t'(16'sh7fff);

    localparam logic FUNC_PUSH    = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_ABS,
        ST_MUL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic shift;
    } win_ctrl_t;

    typedef struct packed {
        logic clear;
        logic step;
    } sort_ctrl_t;

endpackage

FILE: rtl/core/wtm_win_cell.sv
// ----------------------------------------------------------------------------
// wtm_win_cell
// one slot of the sample window, shifts toward the oldest end
// ----------------------------------------------------------------------------
module wtm_win_cell import wtm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  win_ctrl_t ctrl,
    input  sample_t   in_val,
    output sample_t   out_val
);

    sample_t val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
        end else if (ctrl.shift) begin
            val_reg <= in_val;
        end
    end

    assign out_val = val_reg;

endmodule

FILE: rtl/core/wtm_sort_cell.sv
// ----------------------------------------------------------------------------
// wtm_sort_cell
// insertion sort cell, keeps the smaller value and passes the larger on
// ----------------------------------------------------------------------------
module wtm_sort_cell import wtm_pkg::*; (
    input  logic       aclk,
    input  sort_ctrl_t ctrl,
    input  sample_t    in_val,
    output sample_t    hold_val,
    output sample_t    pass_val
);

    sample_t hold_reg;
    sample_t pass_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            hold_reg <= SAMPLE_MAX;
            pass_reg <= SAMPLE_MAX;
        end else if (ctrl.step) begin
            if (in_val < hold_reg) begin
                hold_reg <= in_val;
                pass_reg <= hold_reg;
            end else begin
                pass_reg <= in_val;
            end
        end
    end

    assign hold_val = hold_reg;
    assign pass_val = pass_reg;

endmodule

FILE: rtl/core/windowed_trimmed_mean_filter.sv
// ----------------------------------------------------------------------------
// windowed_trimmed_mean_filter
// Input stream s_*: s_tuser selects the operation (0 push, 1 compute),
// s_tdata carries a signed Q9.6 sample. A push shifts the sample into a
// 40-word window and drops the oldest; it gives no word.
// A compute sorts the window and returns on m_* the mean of sorted
// positions 15 to 24, truncated toward zero.
// A compute clears the systolic sort chain; the window then rotates into
// the chain one word a cycle and the chain keeps stepping until the last
// word has settled. The ten middle taps are then summed one a cycle, and
// the magnitude of the sum is divided by a reciprocal multiply. s_tready
// is low while a compute runs.
// Reset clears the window to zeros; early results count those zeros.
// The result sits in an output register; pushes are still taken while it
// waits. A compute finishing into a stalled output waits in its last state.
// ----------------------------------------------------------------------------
module windowed_trimmed_mean_filter import wtm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic [0:0]  s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] mean
);

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic                    out_valid_reg, out_valid_next;
    logic [15:0]             out_data_reg, out_data_next;

    win_ctrl_t  win_ctrl;
    sort_ctrl_t sort_ctrl;
    sample_t    win_val [WINDOW];
    sample_t    win_in;
    sample_t    sort_hold [WINDOW];
    sample_t    sort_pass [WINDOW];
    sample_t    sort_feed;
    sample_t    taps [TRIM_COUNT];
    sample_t    tap_sel;

    logic                    s_accept;
    logic                    feeding;
    logic signed [SUM_W-1:0] acc_neg;
    logic [QUOT_W-1:0]       quot;
    logic [QUOT_W-1:0]       quot_signed;

    assign s_accept = s_tvalid && s_tready;
    assign feeding  = (state_reg == ST_LOAD) && (cnt_reg < CNT_W'(WINDOW));

    // window ring
    assign win_in = (state_reg == ST_IDLE) ? sample_t'(s_tdata) : win_val[WINDOW-1];

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++) begin : g_win
            wtm_win_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (win_ctrl),
                .in_val  ((gi == 0) ? win_in : win_val[(gi == 0) ? 0 : gi-1]),
                .out_val (win_val[gi])
            );
        end
    endgenerate

    // sort chain
    assign sort_feed = feeding ? win_val[WINDOW-1] : SAMPLE_MAX;

    generate
        for (gi = 0; gi < WINDOW; gi++) begin : g_sort
            wtm_sort_cell u_cell (
                .aclk     (aclk),
                .ctrl     (sort_ctrl),
                .in_val   ((gi == 0) ? sort_feed : sort_pass[(gi == 0) ? 0 : gi-1]),
                .hold_val (sort_hold[gi]),
                .pass_val (sort_pass[gi])
            );
        end
        for (gi = 0; gi < TRIM_COUNT; gi++) begin : g_tap
            assign taps[gi] = sort_hold[TRIM_LOW + gi];
        end
    endgenerate

    assign tap_sel     = taps[cnt_reg[TAP_IDX_W-1:0]];
    assign acc_neg     = -acc_reg;
    assign quot        = prod_reg[RECIP_SHIFT +: QUOT_W];
    assign quot_signed = neg_reg ? (~quot + QUOT_W'(1)) : quot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        prod_next       = prod_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        s_tready        = (state_reg == ST_IDLE);
        win_ctrl.shift  = feeding;
        sort_ctrl.clear = 1'b0;
        sort_ctrl.step  = (state_reg == ST_LOAD);

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser[0] == FUNC_COMPUTE) begin
                        sort_ctrl.clear = 1'b1;
                        cnt_next        = '0;
                        state_next      = ST_LOAD;
                    end else begin
                        win_ctrl.shift = 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(2 * WINDOW - 1)) begin
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                acc_next = acc_reg + SUM_W'(tap_sel);
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TRIM_COUNT - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_ABS;
                end
            end
            ST_ABS: begin
                neg_next   = acc_reg[SUM_W-1];
                mag_next   = acc_reg[SUM_W-1] ? acc_neg[MAG_W-1:0] : acc_reg[MAG_W-1:0];
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = PROD_W'(mag_reg) * PROD_W'(RECIP);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = quot_signed[15:0];
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/core/wtm_checker.sv
// ----------------------------------------------------------------------------
// wtm_checker
// port-level checks of the windowed trimmed mean filter
// ----------------------------------------------------------------------------
`include "windowed_trimmed_mean_filter_macros.svh"

module wtm_checker import wtm_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic push_acc;
    logic comp_acc;
    logic comp_fresh;
    logic out_stall;

    assign push_acc   = s_tvalid && s_tready && (s_tuser[0] == FUNC_PUSH);
    assign comp_acc   = s_tvalid && s_tready && (s_tuser[0] == FUNC_COMPUTE);
    assign comp_fresh = comp_acc && !m_tvalid;
    assign out_stall  = m_tvalid && !m_tready;

    `WTM_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid, "stalled word dropped")
    `WTM_ASSERT_NEXT(a_data_hold, aclk, aresetn, out_stall, $stable(m_tdata), "word changed")
    `WTM_ASSERT_NEXT(a_push_one_cycle, aclk, aresetn, push_acc, s_tready, "push stalled input")
    `WTM_ASSERT_NEXT(a_compute_busy, aclk, aresetn, comp_acc, !s_tready, "input open in compute")
    `WTM_ASSERT_NEXT(a_no_early_result, aclk, aresetn, comp_fresh, !m_tvalid, "early result")

endmodule

bind windowed_trimmed_mean_filter wtm_checker u_wtm_checker (.*);

FILE: tb/windowed_trimmed_mean_filter_tb.sv
// ----------------------------------------------------------------------------
// windowed_trimmed_mean_filter_tb
// Streams push and compute words into the filter with random gaps on the
// input side and random back-pressure on the output side. A local model of
// the 40-sample window sorts a copy on every accepted compute and queues the
// truncated mean of the ten middle samples; each result word is checked
// against the oldest queued mean.
// ----------------------------------------------------------------------------
module windowed_trimmed_mean_filter_tb;
    import wtm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic    func;
        sample_t sample;
        logic    hold;
    } request_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    request_t request_queue [$];
    sample_t  mean_queue [$];

    sample_t  window_model [WINDOW] = '{default: '0};
    int       write_slot = 0;

    int       pushes_taken  = 0;
    int       computes_sent = 0;
    int       results_seen  = 0;
    int       error_count   = 0;
    int       directed_count;

    logic     quiet_tail = 1'b0;
    logic     present;
    logic     idle_mode  = 1'b1;
    int       idle_left;
    request_t cur;

    logic     ready;
    logic     stall_mode = 1'b1;
    int       stall_left;
    sample_t  want;

    windowed_trimmed_mean_filter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [15:0] sample
        .s_tuser  (s_tuser),   // [0] func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [15:0] mean
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic sample_t trimmed_mean_of_window();
        sample_t sorted [WINDOW];
        sample_t key;
        int      j;
        int      acc;
        sorted = window_model;
        for (int i = 1; i < WINDOW; i++) begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        acc = 0;
        for (int i = TRIM_LOW; i < TRIM_LOW + TRIM_COUNT; i++) begin
            acc += int'(sorted[i]);
        end
        return sample_t'(acc / TRIM_COUNT);
    endfunction

    task automatic apply_request(input logic func, input sample_t sample);
        if (func == FUNC_PUSH) begin
            window_model[write_slot] = sample;
            write_slot = (write_slot + 1 >= WINDOW) ? 0 : write_slot + 1;
            pushes_taken++;
        end else begin
            mean_queue.push_back(trimmed_mean_of_window());
            computes_sent++;
        end
    endtask

    task automatic report_error(input string what);
        error_count++;
        if (error_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    task automatic add_request(input logic func, input logic [15:0] sample,
                               input logic hold = 1'b0);
        request_t r;
        r.func   = func;
        r.sample = sample_t'(sample);
        r.hold   = hold;
        request_queue.push_back(r);
    endtask

    function automatic logic [15:0] clustered_sample(input int center);
        int v;
        v = center + int'($urandom_range(0, 20)) - 10;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // input side
    always @(posedge aclk) begin
        present = s_tvalid;
        if (!aresetn) begin
            present   = 1'b0;
            idle_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(s_tuser[0], sample_t'(s_tdata));
                present = 1'b0;
                if ($urandom_range(0, 40) == 0) idle_mode = !idle_mode;
            end
            if (!present) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (request_queue.size() > 0 &&
                             !(request_queue[0].hold && computes_sent != results_seen)) begin
                    cur = request_queue.pop_front();
                    s_tdata <= cur.sample;
                    s_tuser <= cur.func;
                    present = 1'b1;
                    if (!quiet_tail && idle_mode && $urandom_range(0, 3) == 0) begin
                        idle_left = $urandom_range(1, 15);
                    end
                end
            end
        end
        s_tvalid   <= present;
        quiet_tail <= (request_queue.size() < 40);
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (mean_queue.size() == 0) begin
                    report_error($sformatf("unexpected word, mean=%0d", $signed(m_tdata)));
                end else begin
                    want = mean_queue.pop_front();
                    if (m_tdata !== want) begin
                        report_error($sformatf("mean expected %0d, got %0d",
                                               want, $signed(m_tdata)));
                    end
                end
            end
            if ($urandom_range(0, 60) == 0) stall_mode = !stall_mode;
            if (stall_left > 0) begin
                stall_left--;
                ready = 1'b0;
            end else if (!quiet_tail && stall_mode && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 14);
                ready = 1'b0;
            end else begin
                ready = 1'b1;
            end
            m_tready <= ready;
        end
    end

    initial begin
        int random_items;
        int random_computes;
        int kind;
        int run_len;
        int center;
        int extreme_fills;
        logic [15:0] ext;

        // window still all zeros
        add_request(FUNC_COMPUTE, 16'h0000);
        add_request(FUNC_PUSH, 16'h7fff);
        add_request(FUNC_PUSH, 16'h8000);
        add_request(FUNC_PUSH, 16'hffff);
        add_request(FUNC_PUSH, 16'h0001);
        add_request(FUNC_PUSH, 16'h5555);
        add_request(FUNC_PUSH, 16'haaaa);
        add_request(FUNC_PUSH, 16'h0000);
        // sample field ignored on compute
        add_request(FUNC_COMPUTE, 16'hffff);
        add_request(FUNC_COMPUTE, 16'h7fff);
        add_request(FUNC_COMPUTE, 16'h8000, 1'b1);
        for (int i = 0; i < 6; i++) add_request(FUNC_PUSH, 16'hfff9);
        for (int i = 0; i < 6; i++) add_request(FUNC_PUSH, 16'h0007);
        add_request(FUNC_COMPUTE, 16'h0000);
        directed_count = request_queue.size();

        random_items    = 0;
        random_computes = 0;
        extreme_fills   = 0;
        while (random_items < 400 || random_computes < 40) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                run_len = $urandom_range(1, 12);
                for (int i = 0; i < run_len; i++) begin
                    add_request(FUNC_PUSH, 16'($urandom_range(0, 65535)));
                end
                random_items += run_len;
            end else if (kind <= 5) begin
                run_len = $urandom_range(8, 45);
                center  = int'($urandom_range(0, 65535)) - 32768;
                for (int i = 0; i < run_len; i++) begin
                    add_request(FUNC_PUSH, clustered_sample(center));
                end
                random_items += run_len;
            end else if (kind == 6 && extreme_fills < 4) begin
                // window saturated at either end of the range
                ext = extreme_fills[0] ? 16'h8000 : 16'h7fff;
                for (int i = 0; i < WINDOW; i++) begin
                    add_request(FUNC_PUSH, ($urandom_range(0, 7) == 0) ? ~ext : ext);
                end
                extreme_fills++;
                random_items += WINDOW;
            end else if (kind == 7) begin
                add_request(FUNC_COMPUTE, 16'($urandom_range(0, 65535)));
                random_items++;
                random_computes++;
            end else if (kind == 8) begin
                add_request(FUNC_PUSH, 16'($urandom_range(0, 65535)),
                            $urandom_range(0, 9) == 0);
                random_items++;
                continue;
            end
            add_request(FUNC_COMPUTE, 16'($urandom_range(0, 65535)),
                        $urandom_range(0, 11) == 0);
            random_items++;
            random_computes++;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (computes_sent != results_seen) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mean_queue.size() != 0) begin
            $display("%0d means never returned", mean_queue.size());
        end

        $display("run covered %0d directed and %0d random words: %0d pushes, %0d computes",
                 directed_count, random_items, pushes_taken, computes_sent);
        $display("%0d result words checked, %0d mismatches", results_seen, error_count);
        if (error_count == 0 && mean_queue.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout waiting for the filter");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
